FILE: design/assert_macros.svh
// assertion macros used by the compass top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, off during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: design/ecomp_pkg.sv
// types and constants for the compass calibrate and heading unit
// no dependencies
`timescale 1ns / 1ps
package ecomp_pkg;
  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_STOP    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_STOP = 2'd0,
    MODE_RUN  = 2'd1,
    MODE_ACQ  = 2'd2,
    MODE_CAL  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;     // capture item, do the mode and sample work, initialize cordic
    logic start;    // never driven; cordic is initialized by load
    logic iter;     // one cordic iteration
    logic mul;      // scale angle to degrees numerator
    logic finish;   // divide to whole degrees and write heading
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_cordic;
    logic cordic_last;
  } stat_t;

  // atan(2^-i) in Q30, truncated
  function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0: atan_q30 = 32'sd843314856;
      5'd1: atan_q30 = 32'sd497837829;
      5'd2: atan_q30 = 32'sd263043836;
      5'd3: atan_q30 = 32'sd133525158;
      5'd4: atan_q30 = 32'sd67021686;
      5'd5: atan_q30 = 32'sd33543515;
      5'd6: atan_q30 = 32'sd16775850;
      5'd7: atan_q30 = 32'sd8388437;
      5'd8: atan_q30 = 32'sd4194282;
      5'd9: atan_q30 = 32'sd2097149;
      5'd10: atan_q30 = 32'sd1048575;
      5'd11: atan_q30 = 32'sd524287;
      5'd12: atan_q30 = 32'sd262143;
      5'd13: atan_q30 = 32'sd131071;
      5'd14: atan_q30 = 32'sd65535;
      5'd15: atan_q30 = 32'sd32767;
      5'd16: atan_q30 = 32'sd16383;
      5'd17: atan_q30 = 32'sd8191;
      5'd18: atan_q30 = 32'sd4095;
      5'd19: atan_q30 = 32'sd2047;
      5'd20: atan_q30 = 32'sd1023;
      5'd21: atan_q30 = 32'sd511;
      5'd22: atan_q30 = 32'sd255;
      5'd23: atan_q30 = 32'sd127;
      default: atan_q30 = 32'sd0;
    endcase
  endfunction
endpackage

FILE: design/ecomp_if.sv
// valid/ready channel interfaces for the compass unit
// depends on nothing
`timescale 1ns / 1ps
interface ecomp_in_if;
  logic valid;
  logic ready;
  logic [1:0] op;
  logic signed [15:0] mag_x;
  logic signed [15:0] mag_y;
  logic signed [15:0] mag_z;
  modport source (output valid, op, mag_x, mag_y, mag_z, input ready);
  modport sink (input valid, op, mag_x, mag_y, mag_z, output ready);
endinterface

interface ecomp_out_if;
  logic valid;
  logic ready;
  logic [1:0] mode;
  logic [8:0] heading_deg;
  modport source (output valid, mode, heading_deg, input ready);
  modport sink (input valid, mode, heading_deg, output ready);
endinterface

FILE: design/ecomp_ctrl.sv
// controller state machine for the compass unit
// depends on ecomp_pkg
`timescale 1ns / 1ps
module ecomp_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  ecomp_pkg::stat_t stat,
  output ecomp_pkg::cmd_t cmd
);
  ecomp_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ecomp_pkg::ST_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ecomp_pkg::ST_IDLE: if (in_valid) state_next = ecomp_pkg::ST_CORDIC;
      ecomp_pkg::ST_CORDIC: begin
        if (!stat.need_cordic) state_next = ecomp_pkg::ST_OUT;
        else if (stat.cordic_last) state_next = ecomp_pkg::ST_MUL;
      end
      ecomp_pkg::ST_MUL: state_next = ecomp_pkg::ST_DIV;
      ecomp_pkg::ST_DIV: state_next = ecomp_pkg::ST_OUT;
      ecomp_pkg::ST_OUT: if (out_ready) state_next = ecomp_pkg::ST_IDLE;
      default: state_next = ecomp_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      ecomp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ecomp_pkg::ST_CORDIC: begin
        cmd.iter = stat.need_cordic;
      end
      ecomp_pkg::ST_MUL: cmd.mul = 1'b1;
      ecomp_pkg::ST_DIV: cmd.finish = 1'b1;
      ecomp_pkg::ST_OUT: out_valid = 1'b1;
      default: cmd = '0;
    endcase
  end
endmodule

FILE: design/ecomp_datapath.sv
// datapath: mode, min/max tracking, offsets, cordic and degree scaling
// depends on ecomp_pkg
`timescale 1ns / 1ps
module ecomp_datapath #(
  parameter int AXES = 3,
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst,
  input  ecomp_pkg::cmd_t cmd,
  output ecomp_pkg::stat_t stat,
  input  logic [1:0] op,
  input  logic signed [15:0] mag_x,
  input  logic signed [15:0] mag_y,
  input  logic signed [15:0] mag_z,
  output logic [1:0] mode,
  output logic [8:0] heading_deg
);
  localparam int CntW = $clog2(CORDIC_STEPS + 1);

  ecomp_pkg::mode_t cur_mode;
  logic first_pass;
  logic signed [15:0] axis_max [AXES];
  logic signed [15:0] axis_min [AXES];
  logic signed [15:0] axis_offset [AXES];
  logic [8:0] last_heading;

  logic signed [15:0] rd [3];
  logic signed [15:0] cx, cy;
  logic signed [47:0] cx_x, cy_x, cr_x, cr_y; // 16 bits + 2^24 + growth
  logic signed [36:0] cz;
  logic [CntW-1:0] it;
  logic cy_neg;
  logic run_cordic;
  logic signed [47:0] num;   // degrees times 100 * 2^30
  logic [17:0] deg_q;        // num / 2^30 when num is not negative
  logic [31:0] deg_prod;     // reciprocal product for the divide by 100

  assign rd[0] = mag_x;
  assign rd[1] = mag_y;
  assign rd[2] = mag_z;
  assign cx = mag_x - axis_offset[0];
  assign cy = mag_y - axis_offset[1];
  assign mode = cur_mode;
  assign heading_deg = last_heading;
  assign stat.need_cordic = run_cordic;
  assign stat.cordic_last = (it == CntW'(CORDIC_STEPS - 1));

  // divide by 100 * 2^30: drop 30 bits, then multiply by 2^22 / 100 rounded up
  assign deg_q = num[47:30];
  assign deg_prod = deg_q[15:0] * 16'd41944;

  // mode machine and sample work on load, heading write on finish
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mode <= ecomp_pkg::MODE_STOP;
      first_pass <= 1'b1;
      last_heading <= '0;
      run_cordic <= 1'b0;
      for (int i = 0; i < AXES; i++) begin
        axis_max[i] <= '0;
        axis_min[i] <= '0;
        axis_offset[i] <= '0;
      end
    end else if (cmd.load) begin
      run_cordic <= 1'b0;
      case (op)
        ecomp_pkg::OP_ADVANCE: begin
          case (cur_mode)
            ecomp_pkg::MODE_STOP: begin
              cur_mode <= first_pass ? ecomp_pkg::MODE_ACQ : ecomp_pkg::MODE_RUN;
              first_pass <= 1'b0;
            end
            ecomp_pkg::MODE_ACQ: cur_mode <= ecomp_pkg::MODE_CAL;
            ecomp_pkg::MODE_CAL: cur_mode <= ecomp_pkg::MODE_RUN;
            default: cur_mode <= ecomp_pkg::MODE_STOP;
          endcase
        end
        ecomp_pkg::OP_STOP: begin
          first_pass <= 1'b1;
          cur_mode <= ecomp_pkg::MODE_STOP;
        end
        ecomp_pkg::OP_SAMPLE: begin
          case (cur_mode)
            ecomp_pkg::MODE_ACQ: begin
              for (int i = 0; i < AXES; i++) begin
                if (axis_max[i] == 16'sd0 && axis_min[i] == 16'sd0) begin
                  axis_max[i] <= rd[i];
                  axis_min[i] <= rd[i];
                end else begin
                  if (rd[i] > axis_max[i]) axis_max[i] <= rd[i];
                  if (rd[i] < axis_min[i]) axis_min[i] <= rd[i];
                end
              end
            end
            ecomp_pkg::MODE_CAL: begin
              for (int i = 0; i < AXES; i++) begin
                axis_offset[i] <= 16'((17'(axis_max[i]) + 17'(axis_min[i])) / 17'sd2);
              end
            end
            ecomp_pkg::MODE_RUN: begin
              if (cy == 16'sd0) begin
                if (cx > 16'sd0) last_heading <= 9'd0;
                else if (cx < 16'sd0) last_heading <= 9'd180;
              end else begin
                run_cordic <= 1'b1;
              end
            end
            default: run_cordic <= 1'b0;
          endcase
        end
        default: run_cordic <= 1'b0;
      endcase
    end else if (cmd.finish) begin
      // truncate toward zero and clamp to 0..359
      if (num[47]) last_heading <= 9'd0;
      else if (deg_q >= 18'd36000) last_heading <= 9'd359;
      else last_heading <= deg_prod[30:22];
    end
  end

  // cordic vectoring, one iteration a cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cy_neg <= cy[15];
      cr_x <= cy[15] ? -(48'(cy) <<< 24) : (48'(cy) <<< 24);
      cr_y <= cy[15] ? -(48'(cx) <<< 24) : (48'(cx) <<< 24);
      cz <= '0;
      it <= '0;
    end else if (cmd.iter) begin
      if (!cr_y[47]) begin
        cr_x <= cr_x + cx_x;
        cr_y <= cr_y - cy_x;
        cz <= cz + 37'(ecomp_pkg::atan_q30(5'(it)));
      end else begin
        cr_x <= cr_x - cx_x;
        cr_y <= cr_y + cy_x;
        cz <= cz - 37'(ecomp_pkg::atan_q30(5'(it)));
      end
      it <= it + 1'b1;
    end
  end
  assign cx_x = cr_y >>> it;
  assign cy_x = cr_x >>> it;

  // degrees numerator: base * 100 * 2^30 - z * 5729
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      num <= (cy_neg ? (48'sd27000 <<< 30) : (48'sd9000 <<< 30))
             - 48'(cz) * 48'sd5729;
    end
  end
endmodule

FILE: design/ecompass_calibrate_and_heading_unit.sv
// compass unit top level: controller plus datapath
// an op, non-run or degenerate sample passes the CORDIC state straight to the output
// state; a run sample with nonzero corrected y runs CORDIC_STEPS cordic iterations,
// then the scale state and the divide state before the output state
// one item at a time: a new item is taken only after the result is taken; result held until taken.
// rst is synchronous, active high, clears mode, min/max/offsets, heading; sets first pass
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ecompass_calibrate_and_heading_unit #(
  parameter int AXES = 3,
  parameter int CORDIC_STEPS = 16
) (
  input logic clk,
  input logic rst,
  ecomp_in_if.sink in_ch,
  ecomp_out_if.source out_ch
);
  ecomp_pkg::cmd_t cmd;
  ecomp_pkg::stat_t stat;

  ecomp_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat(stat), .cmd(cmd)
  );

  ecomp_datapath #(.AXES(AXES), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .op(in_ch.op), .mag_x(in_ch.mag_x), .mag_y(in_ch.mag_y), .mag_z(in_ch.mag_z),
    .mode(out_ch.mode), .heading_deg(out_ch.heading_deg)
  );

  `ASSERT_IMPL(a_no_overlap, clk, rst, in_ch.ready, !out_ch.valid)
  `ASSERT_NEXT(a_take_starts, clk, rst, in_ch.valid && in_ch.ready, !in_ch.ready)
  `ASSERT_IMPL(a_heading_range, clk, rst, out_ch.valid, out_ch.heading_deg <= 9'd359)
endmodule
